// ===== rtl/ofrs_pkg.sv =====
package ofrs_pkg;

  // Default geometry and beat size
  localparam int DISP_WIDTH_DEF  = 128;
  localparam int DISP_HEIGHT_DEF = 64;
  localparam int BEAT_BYTES_DEF  = 8;

  // Fixed field widths
  localparam int DEV_ADDR_W = 7;
  localparam int SEL_W      = 8;

  // Register reset value and init ROM size
  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RST = 7'd60;
  localparam logic [3:0]            INIT_COUNT   = 4'd14;

  // Transaction bytes
  localparam logic [7:0] CTRL_CMD   = 8'h00;
  localparam logic [7:0] CTRL_DATA  = 8'h40;
  localparam logic [7:0] PAGE_BASE  = 8'hB0;
  localparam logic [7:0] COL_HI_CMD = 8'h10;

  typedef enum logic [2:0] {
    REQ_SET_PIXEL = 3'd0,
    REQ_CLEAR     = 3'd1,
    REQ_POLL      = 3'd2,
    REQ_DONE      = 3'd3,
    REQ_REFRESH   = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_INIT = 2'd0,
    KIND_PAGE = 2'd1,
    KIND_DATA = 2'd2
  } txn_kind_e;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_PAGE = 2'd2,
    MODE_DATA = 2'd3
  } seq_mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WR,
    ST_FETCH,
    ST_DRAIN,
    ST_LOAD
  } ctrl_state_e;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_CLR,
    DP_PIX_RD,
    DP_PIX_WR,
    DP_START,
    DP_FETCH,
    DP_LOAD
  } dp_op_e;

  // Controller to datapath
  typedef struct packed {
    dp_op_e             op;
    txn_kind_e          kind;
    logic [SEL_W-1:0]   sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic pix_ok;
    logic beat_full;
    logic txn_end;
    logic out_free;
  } sts_t;

  // Command bytes of one init ROM entry; second selects the operand byte
  function automatic logic [7:0] init_cmd_byte(input logic [3:0] idx, input logic second,
                                               input logic [7:0] mux_op);
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = 8'h00;
    b1 = 8'h00;
    case (idx)
      4'd0:    begin b0 = 8'hAE; b1 = 8'h00; end
      4'd1:    begin b0 = 8'hD5; b1 = 8'h80; end
      4'd2:    begin b0 = 8'hA8; b1 = mux_op; end
      4'd3:    begin b0 = 8'hD3; b1 = 8'h00; end
      4'd4:    begin b0 = 8'h40; b1 = 8'h00; end
      4'd5:    begin b0 = 8'h8D; b1 = 8'h14; end
      4'd6:    begin b0 = 8'h20; b1 = 8'h02; end
      4'd7:    begin b0 = 8'hA1; b1 = 8'h00; end
      4'd8:    begin b0 = 8'hC8; b1 = 8'h00; end
      4'd9:    begin b0 = 8'hDA; b1 = 8'h12; end
      4'd10:   begin b0 = 8'h81; b1 = 8'h7F; end
      4'd11:   begin b0 = 8'hA4; b1 = 8'h00; end
      4'd12:   begin b0 = 8'hA6; b1 = 8'h00; end
      4'd13:   begin b0 = 8'hAF; b1 = 8'h00; end
      default: begin b0 = 8'h00; b1 = 8'h00; end
    endcase
    return second ? b1 : b0;
  endfunction

  // Bytes in an init transaction: control byte plus one or two command bytes
  function automatic logic [1:0] init_txn_len(input logic [3:0] idx);
    logic [1:0] len;
    case (idx)
      4'd0, 4'd4, 4'd7, 4'd8, 4'd11, 4'd12, 4'd13: len = 2'd2;
      default:                                        len = 2'd3;
    endcase
    return len;
  endfunction

  // Fixed bytes of a transaction; page data past byte zero comes from the store
  function automatic logic [7:0] txn_const_byte(input txn_kind_e kind,
                                                input logic [SEL_W-1:0] sel,
                                                input logic [1:0] pos,
                                                input logic [7:0] mux_op);
    logic [7:0] b;
    b = 8'h00;
    case (kind)
      KIND_INIT: begin
        case (pos)
          2'd0:    b = CTRL_CMD;
          2'd1:    b = init_cmd_byte(sel[3:0], 1'b0, mux_op);
          default: b = init_cmd_byte(sel[3:0], 1'b1, mux_op);
        endcase
      end
      KIND_PAGE: begin
        case (pos)
          2'd0:    b = CTRL_CMD;
          2'd1:    b = PAGE_BASE | sel;
          2'd2:    b = 8'h00;
          default: b = COL_HI_CMD;
        endcase
      end
      KIND_DATA: b = CTRL_DATA;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/ofrs_req_if.sv =====
interface ofrs_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic       pixel_on;
  logic       slot_free;

  modport source (
    output valid, req_type, pixel_x, pixel_y, pixel_on, slot_free,
    input  ready
  );

  modport sink (
    input  valid, req_type, pixel_x, pixel_y, pixel_on, slot_free,
    output ready
  );
endinterface

// ===== rtl/ofrs_beat_if.sv =====
interface ofrs_beat_if;
  logic        valid;
  logic        ready;
  logic [6:0]  device_address_out;
  logic [1:0]  txn_kind;
  logic [63:0] beat_data;
  logic [3:0]  beat_bytes;
  logic        first_beat;
  logic        last_beat;

  modport source (
    output valid, device_address_out, txn_kind, beat_data, beat_bytes, first_beat, last_beat,
    input  ready
  );

  modport sink (
    input  valid, device_address_out, txn_kind, beat_data, beat_bytes, first_beat, last_beat,
    output ready
  );
endinterface

// ===== rtl/ofrs_ram.sv =====
module ofrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ofrs_dp.sv =====
module ofrs_dp #(
  parameter int DISP_WIDTH  = ofrs_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = ofrs_pkg::DISP_HEIGHT_DEF,
  parameter int BEAT_BYTES  = ofrs_pkg::BEAT_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ofrs_pkg::cmd_t                  cmd_i,
  output ofrs_pkg::sts_t                  sts_o,
  input  logic [7:0]                      pixel_x_i,
  input  logic [7:0]                      pixel_y_i,
  input  logic                            pixel_on_i,
  input  logic                            cfg_we_i,
  input  logic [ofrs_pkg::DEV_ADDR_W-1:0] cfg_wdata_i,
  output logic                            beat_valid_o,
  input  logic                            beat_ready_i,
  output logic [ofrs_pkg::DEV_ADDR_W-1:0] device_address_out_o,
  output logic [1:0]                      txn_kind_o,
  output logic [63:0]                     beat_data_o,
  output logic [3:0]                      beat_bytes_o,
  output logic                            first_beat_o,
  output logic                            last_beat_o
);

  localparam int NPAGES = (DISP_HEIGHT + 7) / 8;
  localparam int DEPTH  = NPAGES * DISP_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DISP_WIDTH + 2);
  localparam logic [7:0] MUX_OP = 8'(DISP_HEIGHT - 1);

  logic [ofrs_pkg::DEV_ADDR_W-1:0] dev_addr_q;
  logic [AW-1:0]                   clr_addr_q;
  logic [AW-1:0]                   pix_addr_q, pix_addr_d;
  logic [2:0]                      pix_bit_q;
  logic                            pix_on_q;
  ofrs_pkg::txn_kind_e             kind_q;
  logic [ofrs_pkg::SEL_W-1:0]      sel_q;
  logic [LEN_W-1:0]                len_q, len_d;
  logic [LEN_W-1:0]                pos_q;
  logic [3:0]                      bcnt_q;
  logic                            first_q;
  logic                            land_v_q;
  logic                            land_mem_q;
  logic [7:0]                      land_byte_q;
  logic [2:0]                      land_slot_q;
  logic [63:0]                     buf_q;
  logic                            out_valid_q;
  logic [ofrs_pkg::DEV_ADDR_W-1:0] out_addr_q;
  logic [1:0]                      out_kind_q;
  logic [63:0]                     out_data_q;
  logic [3:0]                      out_bytes_q;
  logic                            out_first_q;
  logic                            out_last_q;

  logic [AW-1:0] fetch_addr;
  logic [7:0]    ram_rdata;
  logic [7:0]    pix_wdata;
  logic [7:0]    pix_mask;
  logic [7:0]    land_data;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          is_fetch;
  logic          is_load;

  assign is_fetch = (cmd_i.op == ofrs_pkg::DP_FETCH);
  assign is_load  = (cmd_i.op == ofrs_pkg::DP_LOAD);

  // Address arithmetic for pixel writes and page data reads
  assign pix_addr_d = AW'(AW'(pixel_y_i[7:3]) * AW'(DISP_WIDTH)) + AW'(pixel_x_i);
  assign fetch_addr = AW'(AW'(sel_q) * AW'(DISP_WIDTH)) + AW'(pos_q) - AW'(1);

  // Read-modify-write of one pixel bit
  assign pix_mask  = 8'(1) << pix_bit_q;
  assign pix_wdata = pix_on_q ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);

  // Memory port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pix_addr_q;
    ram_wdata = pix_wdata;
    ram_raddr = fetch_addr;
    case (cmd_i.op)
      ofrs_pkg::DP_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = 8'h00;
      end
      ofrs_pkg::DP_PIX_RD: ram_raddr = pix_addr_d;
      ofrs_pkg::DP_PIX_WR: ram_we    = 1'b1;
      default: ;
    endcase
  end

  ofrs_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Device address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= ofrs_pkg::DEV_ADDR_RST;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // Advance the clearing sweep, wrap after the last entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.op == ofrs_pkg::DP_CLR) begin
      clr_addr_q <= sts_o.clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  // Hold the pixel request for the write cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ofrs_pkg::DP_PIX_RD) begin
      pix_addr_q <= pix_addr_d;
      pix_bit_q  <= pixel_y_i[2:0];
      pix_on_q   <= pixel_on_i;
    end
  end

  // Transaction length
  always_comb begin
    case (cmd_i.kind)
      ofrs_pkg::KIND_INIT: len_d = LEN_W'(ofrs_pkg::init_txn_len(cmd_i.sel[3:0]));
      ofrs_pkg::KIND_PAGE: len_d = LEN_W'(4);
      default:             len_d = LEN_W'(DISP_WIDTH + 1);
    endcase
  end

  // Transaction and beat counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= ofrs_pkg::KIND_INIT;
      sel_q   <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      bcnt_q  <= '0;
      first_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        ofrs_pkg::DP_START: begin
          kind_q  <= cmd_i.kind;
          sel_q   <= cmd_i.sel;
          len_q   <= len_d;
          pos_q   <= '0;
          bcnt_q  <= '0;
          first_q <= 1'b1;
        end
        ofrs_pkg::DP_FETCH: begin
          pos_q  <= pos_q + 1'b1;
          bcnt_q <= bcnt_q + 1'b1;
        end
        ofrs_pkg::DP_LOAD: begin
          bcnt_q  <= '0;
          first_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Fetch stage: the byte lands in the next cycle, aligned with the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      land_v_q <= 1'b0;
    end else begin
      land_v_q <= is_fetch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_fetch) begin
      land_mem_q  <= (kind_q == ofrs_pkg::KIND_DATA) && (pos_q != '0);
      land_byte_q <= ofrs_pkg::txn_const_byte(kind_q, sel_q, pos_q[1:0], MUX_OP);
      land_slot_q <= bcnt_q[2:0];
    end
  end

  assign land_data = land_mem_q ? ram_rdata : land_byte_q;

  // Assemble the beat; drop it once loaded so unused byte lanes stay zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
    end else if (is_load || cmd_i.op == ofrs_pkg::DP_START) begin
      buf_q <= '0;
    end else if (land_v_q) begin
      buf_q[{land_slot_q, 3'b000} +: 8] <= land_data;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (is_load) begin
      out_valid_q <= 1'b1;
    end else if (beat_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_load) begin
      out_addr_q  <= dev_addr_q;
      out_kind_q  <= kind_q;
      out_data_q  <= buf_q;
      out_bytes_q <= bcnt_q;
      out_first_q <= first_q;
      out_last_q  <= (pos_q == len_q);
    end
  end

  assign beat_valid_o         = out_valid_q;
  assign device_address_out_o = out_addr_q;
  assign txn_kind_o           = out_kind_q;
  assign beat_data_o          = out_data_q;
  assign beat_bytes_o         = out_bytes_q;
  assign first_beat_o         = out_first_q;
  assign last_beat_o          = out_last_q;

  // Status to the controller
  always_comb begin
    sts_o.clr_last  = (clr_addr_q == AW'(DEPTH - 1));
    sts_o.pix_ok    = ({1'b0, pixel_x_i} < 9'(DISP_WIDTH)) &&
                      ({1'b0, pixel_y_i} < 9'(DISP_HEIGHT));
    sts_o.txn_end   = (pos_q == len_q);
    sts_o.beat_full = (bcnt_q == 4'(BEAT_BYTES)) || (pos_q == len_q);
    sts_o.out_free  = !out_valid_q || beat_ready_i;
  end

endmodule

// ===== rtl/ofrs_ctrl.sv =====
module ofrs_ctrl #(
  parameter int DISP_HEIGHT = ofrs_pkg::DISP_HEIGHT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic [2:0]     req_type_i,
  input  logic           slot_free_i,
  input  ofrs_pkg::sts_t sts_i,
  output logic           req_ready_o,
  output ofrs_pkg::cmd_t cmd_o
);

  localparam int NPAGES = (DISP_HEIGHT + 7) / 8;
  localparam int PGW    = $clog2(NPAGES + 1);

  ofrs_pkg::ctrl_state_e       state_q, state_d;
  ofrs_pkg::seq_mode_e         mode_q, mode_d;
  logic [3:0]                  init_idx_q, init_idx_d;
  logic [PGW-1:0]              page_q, page_d;
  logic                        pending_q, pending_d;
  logic                        dirty_q, dirty_d;

  logic                        accept;
  logic                        poll_start;
  ofrs_pkg::txn_kind_e         poll_kind;
  logic [ofrs_pkg::SEL_W-1:0]  poll_sel;
  logic [PGW-1:0]              page_inc;

  assign accept   = req_valid_i && (state_q == ofrs_pkg::ST_IDLE);
  assign page_inc = page_q + 1'b1;

  // Decode the request and update the refresh sequence
  always_comb begin
    mode_d     = mode_q;
    init_idx_d = init_idx_q;
    page_d     = page_q;
    pending_d  = pending_q;
    dirty_d    = dirty_q;
    poll_start = 1'b0;
    poll_kind  = ofrs_pkg::KIND_INIT;
    poll_sel   = '0;
    if (accept) begin
      case (req_type_i)
        ofrs_pkg::REQ_POLL: begin
          if (!pending_q) begin
            case (mode_q)
              ofrs_pkg::MODE_INIT: begin
                if (init_idx_q >= ofrs_pkg::INIT_COUNT) begin
                  mode_d  = ofrs_pkg::MODE_IDLE;
                  dirty_d = 1'b1;
                end else if (slot_free_i) begin
                  poll_start = 1'b1;
                  poll_kind  = ofrs_pkg::KIND_INIT;
                  poll_sel   = ofrs_pkg::SEL_W'(init_idx_q);
                  init_idx_d = init_idx_q + 1'b1;
                  pending_d  = 1'b1;
                end
              end
              ofrs_pkg::MODE_IDLE: begin
                if (dirty_q) begin
                  dirty_d = 1'b0;
                  page_d  = '0;
                  mode_d  = ofrs_pkg::MODE_PAGE;
                  if (slot_free_i) begin
                    poll_start = 1'b1;
                    poll_kind  = ofrs_pkg::KIND_PAGE;
                    poll_sel   = '0;
                    mode_d     = ofrs_pkg::MODE_DATA;
                    pending_d  = 1'b1;
                  end
                end
              end
              ofrs_pkg::MODE_PAGE: begin
                if (slot_free_i) begin
                  poll_start = 1'b1;
                  poll_kind  = ofrs_pkg::KIND_PAGE;
                  poll_sel   = ofrs_pkg::SEL_W'(page_q);
                  mode_d     = ofrs_pkg::MODE_DATA;
                  pending_d  = 1'b1;
                end
              end
              default: begin
                if (slot_free_i) begin
                  if (page_q >= PGW'(NPAGES)) begin
                    mode_d = ofrs_pkg::MODE_IDLE;
                  end else begin
                    poll_start = 1'b1;
                    poll_kind  = ofrs_pkg::KIND_DATA;
                    poll_sel   = ofrs_pkg::SEL_W'(page_q);
                    page_d     = page_inc;
                    mode_d     = (page_inc >= PGW'(NPAGES)) ? ofrs_pkg::MODE_IDLE
                                                            : ofrs_pkg::MODE_PAGE;
                    pending_d  = 1'b1;
                  end
                end
              end
            endcase
          end
        end
        ofrs_pkg::REQ_DONE:    pending_d = 1'b0;
        ofrs_pkg::REQ_REFRESH: dirty_d   = 1'b1;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ofrs_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = ofrs_pkg::ST_IDLE;
        end
      end
      ofrs_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            ofrs_pkg::REQ_SET_PIXEL: begin
              if (sts_i.pix_ok) begin
                state_d = ofrs_pkg::ST_PIX_WR;
              end
            end
            ofrs_pkg::REQ_CLEAR: state_d = ofrs_pkg::ST_CLEAR;
            ofrs_pkg::REQ_POLL: begin
              if (poll_start) begin
                state_d = ofrs_pkg::ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ofrs_pkg::ST_PIX_WR: state_d = ofrs_pkg::ST_IDLE;
      ofrs_pkg::ST_FETCH: begin
        if (sts_i.beat_full) begin
          state_d = ofrs_pkg::ST_DRAIN;
        end
      end
      ofrs_pkg::ST_DRAIN: state_d = ofrs_pkg::ST_LOAD;
      ofrs_pkg::ST_LOAD: begin
        if (sts_i.out_free) begin
          state_d = sts_i.txn_end ? ofrs_pkg::ST_IDLE : ofrs_pkg::ST_FETCH;
        end
      end
      default: state_d = ofrs_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath commands
  always_comb begin
    req_ready_o = (state_q == ofrs_pkg::ST_IDLE);
    cmd_o.op    = ofrs_pkg::DP_NOP;
    cmd_o.kind  = poll_kind;
    cmd_o.sel   = poll_sel;
    case (state_q)
      ofrs_pkg::ST_CLEAR: cmd_o.op = ofrs_pkg::DP_CLR;
      ofrs_pkg::ST_IDLE: begin
        if (accept && req_type_i == ofrs_pkg::REQ_SET_PIXEL && sts_i.pix_ok) begin
          cmd_o.op = ofrs_pkg::DP_PIX_RD;
        end else if (poll_start) begin
          cmd_o.op = ofrs_pkg::DP_START;
        end
      end
      ofrs_pkg::ST_PIX_WR: cmd_o.op = ofrs_pkg::DP_PIX_WR;
      ofrs_pkg::ST_FETCH: begin
        if (!sts_i.beat_full) begin
          cmd_o.op = ofrs_pkg::DP_FETCH;
        end
      end
      ofrs_pkg::ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.op = ofrs_pkg::DP_LOAD;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ofrs_pkg::ST_CLEAR;
      mode_q     <= ofrs_pkg::MODE_INIT;
      init_idx_q <= '0;
      page_q     <= '0;
      pending_q  <= 1'b0;
      dirty_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      init_idx_q <= init_idx_d;
      page_q     <= page_d;
      pending_q  <= pending_d;
      dirty_q    <= dirty_d;
    end
  end

endmodule

// ===== rtl/oled_framebuffer_refresh_sequencer.sv =====
// Channel   Role    Handshake      Payload
// req_i     sink    valid/ready    req_type, pixel_x, pixel_y, pixel_on, slot_free
// beat_o    source  valid/ready    device_address_out, txn_kind, beat_data, beat_bytes,
//                                  first_beat, last_beat
// cfg       write   cfg_we_i       cfg_wdata_i (device address)
//
// The store has a single byte-wide read port, so beats are built one byte per cycle
// while beat_o is not stalled, each beat passing ST_FETCH, ST_DRAIN and ST_LOAD in turn.
// Pixel writes read the byte first, then modify and write it back in ST_PIX_WR.
// After reset, and after each clear request, a clearing pass writes zero to all
// DISP_WIDTH * ceil(DISP_HEIGHT / 8) bytes, one per cycle, with req_i not ready.
// A stalled beat_o holds the sequencer in place; the last beat of a transaction
// may still wait in the output register while the next request is taken.
module oled_framebuffer_refresh_sequencer #(
  parameter int DISP_WIDTH  = ofrs_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = ofrs_pkg::DISP_HEIGHT_DEF,
  parameter int BEAT_BYTES  = ofrs_pkg::BEAT_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ofrs_pkg::DEV_ADDR_W-1:0] cfg_wdata_i,
  ofrs_req_if.sink                        req_i,
  ofrs_beat_if.source                     beat_o
);

  ofrs_pkg::cmd_t cmd;
  ofrs_pkg::sts_t sts;

  ofrs_ctrl #(
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .slot_free_i (req_i.slot_free),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  ofrs_dp #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT),
    .BEAT_BYTES  (BEAT_BYTES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .pixel_x_i            (req_i.pixel_x),
    .pixel_y_i            (req_i.pixel_y),
    .pixel_on_i           (req_i.pixel_on),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .beat_valid_o         (beat_o.valid),
    .beat_ready_i         (beat_o.ready),
    .device_address_out_o (beat_o.device_address_out),
    .txn_kind_o           (beat_o.txn_kind),
    .beat_data_o          (beat_o.beat_data),
    .beat_bytes_o         (beat_o.beat_bytes),
    .first_beat_o         (beat_o.first_beat),
    .last_beat_o          (beat_o.last_beat)
  );

endmodule

// ===== tb/refresh_beat_checker.sv =====
`timescale 1ns / 1ps
module refresh_beat_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ofrs_pkg::DEV_ADDR_W-1:0] cfg_wdata_i,
  ofrs_req_if                             req_mon,
  ofrs_beat_if                            beat_mon,
  output int                              fail_count_o,
  output int                              expected_left_o,
  output int                              beats_checked_o
);

  localparam int DISP_W      = ofrs_pkg::DISP_WIDTH_DEF;
  localparam int DISP_H      = ofrs_pkg::DISP_HEIGHT_DEF;
  localparam int BEAT_MAX    = ofrs_pkg::BEAT_BYTES_DEF;
  localparam int PAGES       = (DISP_H + 7) / 8;
  localparam int STORE_BYTES = PAGES * DISP_W;

  // Init command table, entry 0 in the low byte
  localparam logic [7:0] MUX_RATIO = 8'(DISP_H - 1);
  localparam logic [14*8-1:0] INIT_OPCODES = {
    8'hAF, 8'hA6, 8'hA4, 8'h81, 8'hDA, 8'hC8, 8'hA1,
    8'h20, 8'h8D, 8'h40, 8'hD3, 8'hA8, 8'hD5, 8'hAE
  };
  localparam logic [14*8-1:0] INIT_OPERANDS = {
    8'h00, 8'h00, 8'h00, 8'h7F, 8'h12, 8'h00, 8'h00,
    8'h02, 8'h14, 8'h00, 8'h00, MUX_RATIO, 8'h80, 8'h00
  };
  localparam logic [13:0] INIT_HAS_OPERAND = 14'b00011001101110;

  typedef struct packed {
    logic [ofrs_pkg::DEV_ADDR_W-1:0] addr;
    ofrs_pkg::txn_kind_e             kind;
    logic [63:0]                     data;
    logic [3:0]                      nbytes;
    logic                            first;
    logic                            last;
  } beat_t;

  // Predicted block state
  logic [7:0]                      pixel_pages [STORE_BYTES];
  logic [7:0]                      txn_bytes [DISP_W + 1];
  ofrs_pkg::seq_mode_e             seq_mode;
  logic [3:0]                      init_idx;
  int                              page_idx;
  bit                              transfer_pending;
  bit                              frame_dirty;
  logic [ofrs_pkg::DEV_ADDR_W-1:0] dev_addr;

  beat_t beats_due [$];
  beat_t want;
  beat_t got;
  bit    beat_ok;
  int    errors;
  int    checked;

  task automatic wipe_pages();
    int i;
    for (i = 0; i < STORE_BYTES; i++) pixel_pages[i] = 8'h00;
  endtask

  // Split txn_bytes[0 .. len-1] into beats and queue them
  task automatic queue_transaction_beats(input ofrs_pkg::txn_kind_e kind, input int len);
    int    pos;
    int    cnt;
    int    i;
    beat_t b;
    pos = 0;
    while (pos < len) begin
      cnt = (len - pos > BEAT_MAX) ? BEAT_MAX : len - pos;
      b.data = '0;
      for (i = 0; i < cnt; i++) b.data[8*i +: 8] = txn_bytes[pos + i];
      b.addr   = dev_addr;
      b.kind   = kind;
      b.nbytes = 4'(cnt);
      b.first  = (pos == 0);
      b.last   = (pos + cnt >= len);
      beats_due.push_back(b);
      pos += cnt;
    end
    transfer_pending = 1'b1;
  endtask

  // One bus poll: step the init table or the page refresh
  task automatic advance_sequencer(input logic slot);
    int c;
    if (transfer_pending) return;

    if (seq_mode == ofrs_pkg::MODE_INIT) begin
      if (init_idx >= ofrs_pkg::INIT_COUNT) begin
        seq_mode    = ofrs_pkg::MODE_IDLE;
        frame_dirty = 1'b1;
        return;
      end
      if (!slot) return;
      txn_bytes[0] = ofrs_pkg::CTRL_CMD;
      txn_bytes[1] = INIT_OPCODES[int'(init_idx) * 8 +: 8];
      txn_bytes[2] = INIT_OPERANDS[int'(init_idx) * 8 +: 8];
      queue_transaction_beats(ofrs_pkg::KIND_INIT, INIT_HAS_OPERAND[init_idx] ? 3 : 2);
      init_idx = init_idx + 4'd1;
      return;
    end

    if (seq_mode == ofrs_pkg::MODE_IDLE) begin
      if (!frame_dirty) return;
      frame_dirty = 1'b0;
      page_idx    = 0;
      seq_mode    = ofrs_pkg::MODE_PAGE;
    end

    if (seq_mode == ofrs_pkg::MODE_PAGE) begin
      if (!slot) return;
      txn_bytes[0] = ofrs_pkg::CTRL_CMD;
      txn_bytes[1] = ofrs_pkg::PAGE_BASE | 8'(page_idx);
      txn_bytes[2] = 8'h00;
      txn_bytes[3] = ofrs_pkg::COL_HI_CMD;
      seq_mode = ofrs_pkg::MODE_DATA;
      queue_transaction_beats(ofrs_pkg::KIND_PAGE, 4);
      return;
    end

    // Page data
    if (!slot) return;
    if (page_idx >= PAGES) begin
      seq_mode = ofrs_pkg::MODE_IDLE;
      return;
    end
    txn_bytes[0] = ofrs_pkg::CTRL_DATA;
    for (c = 0; c < DISP_W; c++) txn_bytes[1 + c] = pixel_pages[page_idx * DISP_W + c];
    page_idx++;
    seq_mode = (page_idx >= PAGES) ? ofrs_pkg::MODE_IDLE : ofrs_pkg::MODE_PAGE;
    queue_transaction_beats(ofrs_pkg::KIND_DATA, 1 + DISP_W);
  endtask

  task automatic apply_request(input logic [2:0] code, input logic [7:0] x,
                               input logic [7:0] y, input logic on, input logic slot);
    int idx;
    case (ofrs_pkg::req_type_e'(code))
      ofrs_pkg::REQ_SET_PIXEL: begin
        if (x < DISP_W && y < DISP_H) begin
          idx = (int'(y) / 8) * DISP_W + int'(x);
          pixel_pages[idx][y % 8] = on;
        end
      end
      ofrs_pkg::REQ_CLEAR:   wipe_pages();
      ofrs_pkg::REQ_POLL:    advance_sequencer(slot);
      ofrs_pkg::REQ_DONE:    transfer_pending = 1'b0;
      ofrs_pkg::REQ_REFRESH: frame_dirty = 1'b1;
      default: ;
    endcase
  endtask

  function automatic bit field_ok(input string name, input logic [63:0] exp_val,
                                  input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("beat field %s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Track requests and compare each beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_pages();
      seq_mode         = ofrs_pkg::MODE_INIT;
      init_idx         = '0;
      page_idx         = 0;
      transfer_pending = 1'b0;
      frame_dirty      = 1'b0;
      dev_addr         = ofrs_pkg::DEV_ADDR_RST;
      beats_due.delete();
      errors           = 0;
      checked          = 0;
      fail_count_o    <= 0;
      expected_left_o <= 0;
      beats_checked_o <= 0;
    end else begin
      if (cfg_we_i) dev_addr = cfg_wdata_i;

      if (req_mon.valid && req_mon.ready) begin
        apply_request(req_mon.req_type, req_mon.pixel_x, req_mon.pixel_y,
                      req_mon.pixel_on, req_mon.slot_free);
      end

      if (beat_mon.valid && beat_mon.ready) begin
        got.addr   = beat_mon.device_address_out;
        got.kind   = ofrs_pkg::txn_kind_e'(beat_mon.txn_kind);
        got.data   = beat_mon.beat_data;
        got.nbytes = beat_mon.beat_bytes;
        got.first  = beat_mon.first_beat;
        got.last   = beat_mon.last_beat;
        if (beats_due.size() == 0) begin
          $error("unexpected beat: kind %0d data 0x%016h bytes %0d",
                 got.kind, got.data, got.nbytes);
          errors++;
        end else begin
          want    = beats_due.pop_front();
          beat_ok = field_ok("device_address_out", 64'(want.addr), 64'(got.addr));
          beat_ok = field_ok("txn_kind", 64'(want.kind), 64'(got.kind)) & beat_ok;
          beat_ok = field_ok("beat_data", want.data, got.data) & beat_ok;
          beat_ok = field_ok("beat_bytes", 64'(want.nbytes), 64'(got.nbytes)) & beat_ok;
          beat_ok = field_ok("first_beat", 64'(want.first), 64'(got.first)) & beat_ok;
          beat_ok = field_ok("last_beat", 64'(want.last), 64'(got.last)) & beat_ok;
          if (!beat_ok) errors++;
          checked++;
        end
      end

      fail_count_o    <= errors;
      expected_left_o <= beats_due.size();
      beats_checked_o <= checked;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 4;
  // Long enough to cover a full clearing pass of the store
  localparam int SETTLE_CYCLES = 1100;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 26;
  localparam int DISP_W        = ofrs_pkg::DISP_WIDTH_DEF;
  localparam int DISP_H        = ofrs_pkg::DISP_HEIGHT_DEF;

  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  localparam logic [ofrs_pkg::DEV_ADDR_W-1:0] ADDR_MIN = '0;
  localparam logic [ofrs_pkg::DEV_ADDR_W-1:0] ADDR_MAX = '1;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ofrs_pkg::DEV_ADDR_W-1:0] cfg_wdata;
  logic                            sink_ready = 1'b0;
  bit                              sink_calm;
  bit                              req_calm;
  bit                              req_up;
  int                              hold_cnt;
  int                              cycle_count;
  int                              fail_count;
  int                              expected_left;
  int                              beats_checked;
  int                              requests_sent;

  ofrs_req_if  req_ch ();
  ofrs_beat_if beat_ch ();

  assign beat_ch.ready = sink_ready;

  oled_framebuffer_refresh_sequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .beat_o      (beat_ch)
  );

  refresh_beat_checker beat_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .req_mon         (req_ch),
    .beat_mon        (beat_ch),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left),
    .beats_checked_o (beats_checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short idle spans, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Stall the beat channel at random, with calm stretches in between
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) sink_calm <= !sink_calm;
    if (hold_cnt > 0) begin
      sink_ready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else if (!sink_calm && $urandom_range(0, 99) < 30) begin
      sink_ready <= 1'b0;
      hold_cnt   <= idle_span() - 1;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it
  task automatic send_request(input logic [2:0] code, input logic [7:0] x,
                              input logic [7:0] y, input logic on, input logic slot);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < 5) req_calm = !req_calm;
    if (!req_calm && $urandom_range(0, 99) < 35) gap = idle_span();
    if (gap > 0) begin
      if (req_up) req_ch.valid <= 1'b0;
      req_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (!req_up) begin
      req_ch.valid <= 1'b1;
      req_up = 1'b1;
    end
    req_ch.req_type  <= code;
    req_ch.pixel_x   <= x;
    req_ch.pixel_y   <= y;
    req_ch.pixel_on  <= on;
    req_ch.slot_free <= slot;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  // Request whose pixel fields carry random filler
  task automatic send_plain(input logic [2:0] code, input logic slot);
    send_request(code, 8'($urandom), 8'($urandom), 1'($urandom), slot);
  endtask

  // Drop valid, wait for every predicted beat, then let the block go quiet
  task automatic settle_block();
    if (req_up) req_ch.valid <= 1'b0;
    req_up = 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_device_address(input logic [ofrs_pkg::DEV_ADDR_W-1:0] addr);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly poll/done pairs so the sequencer keeps moving, plus noise
  task automatic random_phase(input int n_items);
    int         sent;
    int         pick;
    logic [7:0] x;
    logic [7:0] y;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 60) begin
        send_plain(ofrs_pkg::REQ_POLL, $urandom_range(0, 5) != 0);
        send_plain(ofrs_pkg::REQ_DONE, 1'($urandom));
        sent += 2;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          x = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, DISP_W - 1));
          y = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, DISP_H - 1));
          send_request(ofrs_pkg::REQ_SET_PIXEL, x, y, 1'($urandom_range(0, 3) != 0),
                       1'($urandom));
        end else if (pick < 60) begin
          send_plain(ofrs_pkg::REQ_POLL, 1'($urandom));
        end else if (pick < 75) begin
          send_plain(ofrs_pkg::REQ_DONE, 1'($urandom));
        end else if (pick < 88) begin
          send_plain(ofrs_pkg::REQ_REFRESH, 1'($urandom));
        end else if (pick < 92) begin
          send_plain(ofrs_pkg::REQ_CLEAR, 1'($urandom));
        end else begin
          send_plain(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), 1'($urandom));
        end
        sent++;
      end
    end
  endtask

  initial begin
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= ofrs_pkg::REQ_DONE;
    req_ch.pixel_x   <= '0;
    req_ch.pixel_y   <= '0;
    req_ch.pixel_on  <= 1'b0;
    req_ch.slot_free <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    rst_n            <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Pixel corners, darkening, out-of-range writes and a clear
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'd0, 8'd0, 1'b1, 1'b0);
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'(DISP_W - 1), 8'(DISP_H - 1), 1'b1, 1'b1);
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'(DISP_W - 1), 8'(DISP_H - 1), 1'b0, 1'b0);
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'(DISP_W - 1), 8'(DISP_H - 1), 1'b1, 1'b1);
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'(DISP_W), 8'd0, 1'b1, 1'b0);
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'd0, 8'(DISP_H), 1'b1, 1'b1);
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_plain(ofrs_pkg::REQ_CLEAR, 1'b0);
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'd0, 8'd0, 1'b1, 1'b0);
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'(DISP_W - 1), 8'(DISP_H - 1), 1'b1, 1'b0);
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'd5, 8'd7, 1'b1, 1'b1);
    send_request(ofrs_pkg::REQ_SET_PIXEL, 8'd64, 8'd8, 1'b1, 1'b0);

    // Unused codes, busy slot, refresh during init, poll while a transfer is open
    send_request(REQ_UNUSED_LO, 8'h00, 8'h00, 1'b0, 1'b0);
    send_request(REQ_UNUSED_HI, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_plain(ofrs_pkg::REQ_POLL, 1'b0);
    send_plain(ofrs_pkg::REQ_REFRESH, 1'b1);
    send_plain(ofrs_pkg::REQ_POLL, 1'b1);
    send_plain(ofrs_pkg::REQ_POLL, 1'b1);
    send_plain(ofrs_pkg::REQ_DONE, 1'b0);
    send_plain(ofrs_pkg::REQ_POLL, 1'b1);
    send_plain(ofrs_pkg::REQ_DONE, 1'b1);
    send_plain(ofrs_pkg::REQ_DONE, 1'b0);

    // Random traffic under both extreme device addresses and a random one
    set_device_address(ADDR_MAX);
    random_phase(PHASE_ITEMS);
    set_device_address(ADDR_MIN);
    random_phase(PHASE_ITEMS);
    set_device_address(7'($urandom_range(1, 126)));
    random_phase(PHASE_ITEMS);
    settle_block();

    if (expected_left != 0) $error("%0d predicted beats never arrived", expected_left);
    $display("Run covered %0d requests: pixel writes, clears, polls, done, refresh, unused codes.",
             requests_sent);
    $display("Checked %0d beats across init, page address and page data transfers.",
             beats_checked);
    if (fail_count == 0 && expected_left == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== oled_framebuffer_refresh_sequencer.f =====
rtl/ofrs_pkg.sv
rtl/ofrs_req_if.sv
rtl/ofrs_beat_if.sv
rtl/ofrs_ram.sv
rtl/ofrs_dp.sv
rtl/ofrs_ctrl.sv
rtl/oled_framebuffer_refresh_sequencer.sv
tb/refresh_beat_checker.sv
tb/tb_top.sv
